// ===== src/rsps_pkg.sv =====
// Shared types and constants for the ramp/soak profile sequencer.
`timescale 1ns / 1ps
`default_nettype none
package rsps_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_RUN  = 3'd1,
        MODE_WAIT = 3'd2,
        MODE_FIN  = 3'd3,
        MODE_STOP = 3'd4,
        MODE_ERR  = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        REQ_TICK  = 3'd0,
        REQ_START = 3'd1,
        REQ_STOP  = 3'd2,
        REQ_ERROR = 3'd3,
        REQ_RESET = 3'd4,
        REQ_WRITE = 3'd5
    } t_req;

    typedef enum logic [2:0] {
        NOTE_PSTART   = 3'd0,
        NOTE_SSTART   = 3'd1,
        NOTE_OSET     = 3'd2,
        NOTE_ORESET   = 3'd3,
        NOTE_STOPPED  = 3'd4,
        NOTE_FINISHED = 3'd5,
        NOTE_READY    = 3'd6
    } t_note;

    typedef enum logic [1:0] {
        KIND_HEAT = 2'd0,
        KIND_HOLD = 2'd1,
        KIND_COOL = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_RD0  = 3'd1,
        ST_RD1  = 3'd2,
        ST_EXEC = 3'd3,
        ST_EMIT = 3'd4
    } t_ctrl_state;

    localparam int NUM_OUT_BITS = 8;
    localparam int MAX_NOTES    = 10;
    localparam int TEMP_W       = 13;

    localparam logic [0:0] CFG_PRESTEP = 1'b0;
    localparam logic [0:0] CFG_AMBIENT = 1'b1;

    localparam logic signed [7:0] AMBIENT_RESET = 8'sd20;

    typedef struct packed {
        logic [11:0] setpoint;
        logic [15:0] duration;
        logic [7:0]  outputs;
    } t_step_entry;

    typedef struct packed {
        logic take;
        logic rd1;
        logic exec;
        logic pop;
    } t_dp_cmd;

    typedef struct packed {
        logic       is_write;
        logic [3:0] remaining;
    } t_dp_status;

endpackage
`default_nettype wire

// ===== src/rsps_table.sv =====
// Step table memory with per-entry valid bits; unwritten entries read as end markers.
`timescale 1ns / 1ps
`default_nettype none
module rsps_table #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire rsps_pkg::t_step_entry i_wdata,
    input  wire logic [AW-1:0]        i_raddr,
    output rsps_pkg::t_step_entry     o_rdata
);
    import rsps_pkg::*;

    t_step_entry r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    t_step_entry r_rdata;
    logic r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule
`default_nettype wire

// ===== src/rsps_datapath.sv =====
// Sequencer datapath: config, profile state, step table and pending notification set.
`timescale 1ns / 1ps
`default_nettype none
module rsps_datapath #(
    parameter int STEP_COUNT = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [0:0]           i_cfg_idx,
    input  wire logic [7:0]           i_cfg_wdata,
    input  wire logic [2:0]           i_req_type,
    input  wire logic [3:0]           i_step_index,
    input  wire logic [11:0]          i_step_setpoint,
    input  wire logic [15:0]          i_step_duration,
    input  wire logic [7:0]           i_step_outputs,
    input  wire rsps_pkg::t_dp_cmd    i_cmd,
    output rsps_pkg::t_dp_status      o_status,
    output logic [2:0]                o_note_type,
    output logic [3:0]                o_note_arg,
    output logic [2:0]                o_state_code,
    output logic [4:0]                o_step_number,
    output logic [7:0]                o_output_bits,
    output logic [15:0]               o_profile_time,
    output logic [15:0]               o_step_time,
    output logic [1:0]                o_step_kind,
    output logic [11:0]               o_target_now
);
    import rsps_pkg::*;

    localparam int PW = $clog2(STEP_COUNT + 1);
    localparam int AW = $clog2(STEP_COUNT);

    // configuration
    logic [7:0]        r_prestep;
    logic signed [7:0] r_ambient;

    // profile state
    t_mode                    r_mode, n_mode;
    logic [PW-1:0]            r_ptr, n_ptr;
    logic [15:0]              r_pt, n_pt;
    logic [15:0]              r_st, n_st;
    logic signed [TEMP_W-1:0] r_sst, n_sst;
    logic [7:0]               r_out, n_out;
    logic [11:0]              r_target;
    t_kind                    r_kind;

    // latched request and table reads
    logic [2:0]  r_req;
    t_step_entry r_e0;
    t_step_entry w_e1;
    t_step_entry w_tab_rdata;

    // pending notifications, emitted in this order: a, b, bit changes, qa, qb
    logic        r_pa_v, n_pa_v;
    t_note       r_pa_t, n_pa_t;
    logic [3:0]  r_pa_arg, n_pa_arg;
    logic        r_pb_v, n_pb_v;
    logic [7:0]  r_chg;
    logic        r_qa_v, n_qa_v;
    t_note       r_qa_t, n_qa_t;
    logic [3:0]  r_qa_arg, n_qa_arg;
    logic        r_qb_v, n_qb_v;

    logic          w_start_idle;
    logic          w_ptr_ok;
    logic          w_next_ok;
    logic          w_a0_ok;
    logic [AW-1:0] w_raddr;
    logic          w_tab_we;
    t_step_entry   w_tab_wdata;
    logic [PW-1:0] w_ptr_inc;
    logic [15:0]   w_st_inc;
    logic          w_moved;
    logic [11:0]   w_tgt;
    logic signed [TEMP_W-1:0] w_tgt_s;
    t_kind         w_kind;
    logic [2:0]    w_low;

    assign w_start_idle = (r_mode == MODE_IDLE) && (r_req == REQ_START);
    assign w_ptr_ok     = r_ptr < PW'(STEP_COUNT);
    assign w_next_ok    = r_ptr < PW'(STEP_COUNT - 1);
    assign w_a0_ok      = w_start_idle || w_ptr_ok;
    assign w_ptr_inc    = r_ptr + 1'b1;
    assign w_st_inc     = r_st + 16'd1;

    // first read at the current step (step 0 for a start), second at the next step
    always_comb begin
        if (i_cmd.rd1) begin
            w_raddr = w_next_ok ? AW'(w_ptr_inc) : '0;
        end else if (w_start_idle || !w_ptr_ok) begin
            w_raddr = '0;
        end else begin
            w_raddr = AW'(r_ptr);
        end
    end

    assign w_tab_we = i_cmd.take && (i_req_type == REQ_WRITE)
                      && (int'(i_step_index) < STEP_COUNT);
    assign w_tab_wdata = '{setpoint: i_step_setpoint, duration: i_step_duration,
                           outputs: i_step_outputs};

    rsps_table #(
        .DEPTH (STEP_COUNT),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_tab_we),
        .i_waddr (AW'(i_step_index)),
        .i_wdata (w_tab_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_tab_rdata)
    );

    assign w_e1 = w_next_ok ? w_tab_rdata : '0;

    // event execution against the old state
    always_comb begin
        n_mode   = r_mode;
        n_ptr    = r_ptr;
        n_pt     = r_pt;
        n_st     = r_st;
        n_sst    = r_sst;
        n_out    = r_out;
        n_pa_v   = 1'b0;
        n_pa_t   = NOTE_PSTART;
        n_pa_arg = '0;
        n_pb_v   = 1'b0;
        n_qa_v   = 1'b0;
        n_qa_t   = NOTE_STOPPED;
        n_qa_arg = '0;
        n_qb_v   = (r_req == REQ_TICK);
        w_moved  = 1'b0;
        if (r_req == REQ_ERROR) begin
            if (r_mode != MODE_ERR) begin
                n_out  = '0;
                n_mode = MODE_ERR;
            end
        end else begin
            unique case (r_mode)
                MODE_IDLE: begin
                    if (r_req == REQ_START) begin
                        n_ptr  = '0;
                        n_pt   = '0;
                        n_st   = '0;
                        n_sst  = {{(TEMP_W-8){r_ambient[7]}}, r_ambient};
                        n_pa_v = 1'b1;
                        if (r_prestep != '0) begin
                            n_out  = r_prestep;
                            n_mode = MODE_WAIT;
                        end else begin
                            n_pb_v = 1'b1;
                            n_out  = r_e0.outputs;
                            n_mode = MODE_RUN;
                        end
                    end
                end
                MODE_RUN: begin
                    if (r_req == REQ_STOP) begin
                        n_out    = '0;
                        n_qa_v   = 1'b1;
                        n_qa_arg = 4'(r_ptr);
                        n_mode   = MODE_STOP;
                    end else begin
                        n_pt = r_pt + 16'd1;
                        n_st = w_st_inc;
                        if (w_ptr_ok && (w_st_inc >= r_e0.duration)) begin
                            n_ptr   = w_ptr_inc;
                            w_moved = 1'b1;
                            if (!w_next_ok ||
                                (w_e1.setpoint == '0 && w_e1.duration == '0)) begin
                                n_out  = '0;
                                n_qa_v = 1'b1;
                                n_qa_t = NOTE_FINISHED;
                                n_mode = MODE_FIN;
                            end else begin
                                n_sst    = {1'b0, r_e0.setpoint};
                                n_st     = '0;
                                n_pa_v   = 1'b1;
                                n_pa_t   = NOTE_SSTART;
                                n_pa_arg = 4'(w_ptr_inc);
                                n_out    = w_e1.outputs;
                            end
                        end
                    end
                end
                MODE_WAIT: begin
                    if (r_req == REQ_STOP) begin
                        n_out    = '0;
                        n_qa_v   = 1'b1;
                        n_qa_arg = 4'(r_ptr);
                        n_mode   = MODE_STOP;
                    end else if (r_req == REQ_RESET) begin
                        n_pa_v   = 1'b1;
                        n_pa_t   = NOTE_SSTART;
                        n_pa_arg = 4'(r_ptr);
                        if (w_ptr_ok) begin
                            n_out = r_e0.outputs;
                        end
                        n_mode = MODE_RUN;
                    end
                end
                default: begin
                    if (r_req == REQ_RESET) begin
                        n_mode = MODE_IDLE;
                    end
                end
            endcase
        end
    end

    assign w_tgt   = w_moved ? w_e1.setpoint : r_e0.setpoint;
    assign w_tgt_s = signed'({1'b0, w_tgt});

    always_comb begin
        if (w_tgt_s > n_sst) begin
            w_kind = KIND_HEAT;
        end else if (w_tgt_s < n_sst) begin
            w_kind = KIND_COOL;
        end else begin
            w_kind = KIND_HOLD;
        end
    end

    always_comb begin
        w_low = '0;
        for (int b = NUM_OUT_BITS - 1; b >= 0; b--) begin
            if (r_chg[b]) begin
                w_low = 3'(b);
            end
        end
    end

    // present the first pending notification
    always_comb begin
        if (r_pa_v) begin
            o_note_type = r_pa_t;
            o_note_arg  = r_pa_arg;
        end else if (r_pb_v) begin
            o_note_type = NOTE_SSTART;
            o_note_arg  = '0;
        end else if (r_chg != '0) begin
            o_note_type = r_out[w_low] ? NOTE_OSET : NOTE_ORESET;
            o_note_arg  = {1'b0, w_low};
        end else if (r_qa_v) begin
            o_note_type = r_qa_t;
            o_note_arg  = r_qa_arg;
        end else begin
            o_note_type = NOTE_READY;
            o_note_arg  = '0;
        end
    end

    assign o_status.is_write  = (i_req_type == REQ_WRITE);
    assign o_status.remaining = 4'({3'b0, r_pa_v}) + 4'({3'b0, r_pb_v})
                                + 4'($countones(r_chg)) + 4'({3'b0, r_qa_v})
                                + 4'({3'b0, r_qb_v});

    // request latch, first table read, execution results
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_req <= i_req_type;
        end
        if (i_cmd.rd1) begin
            r_e0 <= w_a0_ok ? w_tab_rdata : '0;
        end
        if (i_cmd.exec) begin
            r_pa_t   <= n_pa_t;
            r_pa_arg <= n_pa_arg;
            r_qa_t   <= n_qa_t;
            r_qa_arg <= n_qa_arg;
            r_target <= w_tgt;
            r_kind   <= w_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prestep <= '0;
            r_ambient <= AMBIENT_RESET;
            r_mode    <= MODE_IDLE;
            r_ptr     <= '0;
            r_pt      <= '0;
            r_st      <= '0;
            r_sst     <= '0;
            r_out     <= '0;
            r_pa_v    <= 1'b0;
            r_pb_v    <= 1'b0;
            r_chg     <= '0;
            r_qa_v    <= 1'b0;
            r_qb_v    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PRESTEP: r_prestep <= i_cfg_wdata;
                    CFG_AMBIENT: r_ambient <= signed'(i_cfg_wdata);
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                r_mode <= n_mode;
                r_ptr  <= n_ptr;
                r_pt   <= n_pt;
                r_st   <= n_st;
                r_sst  <= n_sst;
                r_out  <= n_out;
                r_pa_v <= n_pa_v;
                r_pb_v <= n_pb_v;
                r_chg  <= r_out ^ n_out;
                r_qa_v <= n_qa_v;
                r_qb_v <= n_qb_v;
            end else if (i_cmd.pop) begin
                // drop the notification just taken
                if (r_pa_v) begin
                    r_pa_v <= 1'b0;
                end else if (r_pb_v) begin
                    r_pb_v <= 1'b0;
                end else if (r_chg != '0) begin
                    r_chg <= r_chg & (r_chg - 8'd1);
                end else if (r_qa_v) begin
                    r_qa_v <= 1'b0;
                end else begin
                    r_qb_v <= 1'b0;
                end
            end
        end
    end

    assign o_state_code   = r_mode;
    assign o_step_number  = 5'(r_ptr);
    assign o_output_bits  = r_out;
    assign o_profile_time = r_pt;
    assign o_step_time    = r_st;
    assign o_step_kind    = r_kind;
    assign o_target_now   = r_target;

endmodule
`default_nettype wire

// ===== src/rsps_ctrl.sv =====
// Sequencer controller: transaction intake, table read steps, execute and notification emit.
`timescale 1ns / 1ps
`default_nettype none
module rsps_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_last,
    input  wire rsps_pkg::t_dp_status i_status,
    output rsps_pkg::t_dp_cmd         o_cmd
);
    import rsps_pkg::*;

    t_ctrl_state r_state, n_state;
    logic [3:0]  r_cnt, n_cnt;
    logic        w_valid;
    logic        w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        w_valid    = 1'b0;
        w_last     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_cnt      = '0;
                    // table writes finish in the accepting cycle
                    if (!i_status.is_write) begin
                        n_state = ST_RD0;
                    end
                end
            end
            ST_RD0: begin
                n_state = ST_RD1;
            end
            ST_RD1: begin
                o_cmd.rd1 = 1'b1;
                n_state   = ST_EXEC;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                w_valid = (i_status.remaining != '0) && (r_cnt != 4'(MAX_NOTES));
                w_last  = (i_status.remaining == 4'd1) || (r_cnt == 4'(MAX_NOTES - 1));
                if (!w_valid) begin
                    n_state = ST_IDLE;
                end else if (i_out_ready) begin
                    o_cmd.pop = 1'b1;
                    n_cnt     = r_cnt + 4'd1;
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = w_valid;
    assign o_last      = w_last;

endmodule
`default_nettype wire

// ===== src/ramp_soak_profile_sequencer_core.sv =====
// Top level of the ramp/soak profile sequencer.
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one event per transaction:
//   tick, start, stop, error, reset or a step table write.
//   Output channel (o_out_valid / i_out_ready) carries the notifications an
//   event causes, one per transaction, o_last set on the final one. Status
//   fields show the state after the whole event and hold for all its notes.
//   Config port: i_cfg_we writes i_cfg_wdata into register i_cfg_idx
//   (0 pre-step outputs, 1 ambient temperature); write only while idle.
// Timing:
//   A table write completes in the accepting cycle. Any other event makes two
//   registered step table reads and an execute step, then emits its notifications
//   (at most 10), one per cycle while the receiver takes them. A stalled
//   receiver holds the current notification; no new event is accepted until
//   the last one is taken.
// Reset: synchronous, active low; clears state, registers to their defaults
//   and marks every table entry as an end marker at once.
`timescale 1ns / 1ps
`default_nettype none
module ramp_soak_profile_sequencer_core #(
    parameter int STEP_COUNT = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [3:0]  i_step_index,
    input  wire logic [11:0] i_step_setpoint,
    input  wire logic [15:0] i_step_duration,
    input  wire logic [7:0]  i_step_outputs,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_note_type,
    output logic [3:0]       o_note_arg,
    output logic [2:0]       o_state_code,
    output logic [4:0]       o_step_number,
    output logic [7:0]       o_output_bits,
    output logic [15:0]      o_profile_time,
    output logic [15:0]      o_step_time,
    output logic [1:0]       o_step_kind,
    output logic [11:0]      o_target_now,
    output logic             o_last
);
    import rsps_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    rsps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_last      (o_last),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    rsps_datapath #(
        .STEP_COUNT (STEP_COUNT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_req_type      (i_req_type),
        .i_step_index    (i_step_index),
        .i_step_setpoint (i_step_setpoint),
        .i_step_duration (i_step_duration),
        .i_step_outputs  (i_step_outputs),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_note_type     (o_note_type),
        .o_note_arg      (o_note_arg),
        .o_state_code    (o_state_code),
        .o_step_number   (o_step_number),
        .o_output_bits   (o_output_bits),
        .o_profile_time  (o_profile_time),
        .o_step_time     (o_step_time),
        .o_step_kind     (o_step_kind),
        .o_target_now    (o_target_now)
    );

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the ramp/soak profile sequencer core.
`timescale 1ns / 1ps

import rsps_pkg::*;

typedef struct packed {
    t_note       note;
    logic [3:0]  arg;
    t_mode       mode;
    logic [4:0]  step;
    logic [7:0]  outs;
    logic [15:0] ptime;
    logic [15:0] stime;
    t_kind       kind;
    logic [11:0] target;
    logic        last;
} t_note_rec;

class profile_scoreboard #(int STEPS = 16);
    logic [11:0] tab_set [STEPS];
    logic [15:0] tab_dur [STEPS];
    logic [7:0]  tab_out [STEPS];
    logic [7:0]  prestep;
    int          ambient;
    t_mode       mode;
    int          ptr;
    logic [15:0] ptime;
    logic [15:0] stime;
    int          start_temp;
    logic [7:0]  outs;
    t_note       burst_note [$];
    logic [3:0]  burst_arg [$];
    t_note_rec   pending_notes [$];
    int          mismatches;

    function new();
        foreach (tab_set[i]) begin
            tab_set[i] = '0;
            tab_dur[i] = '0;
            tab_out[i] = '0;
        end
        prestep    = '0;
        ambient    = AMBIENT_RESET;
        mode       = MODE_IDLE;
        ptr        = 0;
        ptime      = '0;
        stime      = '0;
        start_temp = 0;
        outs       = '0;
        mismatches = 0;
    endfunction

    function void set_register(logic [0:0] idx, logic [7:0] v);
        if (idx == CFG_PRESTEP) begin
            prestep = v;
        end else begin
            ambient = int'($signed(v));
        end
    endfunction

    function void post(t_note n, int arg);
        if (burst_note.size() < MAX_NOTES) begin
            burst_note.push_back(n);
            burst_arg.push_back(arg[3:0]);
        end
    endfunction

    // Report every changed bit, lowest first
    function void drive_outs(logic [7:0] v);
        logic [7:0] rise;
        logic [7:0] fall;
        rise = (outs ^ v) & v;
        fall = (outs ^ v) & outs;
        outs = v;
        for (int b = 0; b < NUM_OUT_BITS; b++) begin
            if (rise[b]) post(NOTE_OSET, b);
            if (fall[b]) post(NOTE_ORESET, b);
        end
    endfunction

    function void open_step();
        post(NOTE_SSTART, ptr);
        if (ptr < STEPS) drive_outs(tab_out[ptr]);
    endfunction

    function void stop_profile();
        drive_outs(8'h00);
        post(NOTE_STOPPED, ptr);
        mode = MODE_STOP;
    endfunction

    // Check the bound before touching the table
    function void advance();
        ptr++;
        if (ptr >= STEPS || (tab_set[ptr] == 0 && tab_dur[ptr] == 0)) begin
            drive_outs(8'h00);
            post(NOTE_FINISHED, 0);
            mode = MODE_FIN;
        end else begin
            start_temp = int'(tab_set[ptr - 1]);
            stime      = '0;
            open_step();
            mode = MODE_RUN;
        end
    endfunction

    function void count_tick();
        ptime++;
        stime++;
        if (ptr < STEPS && stime >= tab_dur[ptr]) advance();
    endfunction

    function void take_event(logic [2:0] req, logic [3:0] idx, logic [11:0] setp,
                             logic [15:0] dur, logic [7:0] outp);
        logic [11:0] target;
        t_kind       kind;
        burst_note.delete();
        burst_arg.delete();
        if (req == REQ_WRITE) begin
            if (idx < STEPS) begin
                tab_set[idx] = setp;
                tab_dur[idx] = dur;
                tab_out[idx] = outp;
            end
        end else if (req == REQ_ERROR) begin
            if (mode != MODE_ERR) begin
                drive_outs(8'h00);
                mode = MODE_ERR;
            end
        end else begin
            case (mode)
                MODE_IDLE: begin
                    if (req == REQ_START) begin
                        ptr        = 0;
                        ptime      = '0;
                        stime      = '0;
                        start_temp = ambient;
                        post(NOTE_PSTART, 0);
                        if (prestep != 0) begin
                            drive_outs(prestep);
                            mode = MODE_WAIT;
                        end else begin
                            open_step();
                            mode = MODE_RUN;
                        end
                    end
                end
                MODE_RUN: begin
                    if (req == REQ_STOP) stop_profile();
                    else count_tick();
                end
                MODE_WAIT: begin
                    if (req == REQ_STOP) begin
                        stop_profile();
                    end else if (req == REQ_RESET) begin
                        open_step();
                        mode = MODE_RUN;
                    end
                end
                default: begin
                    if (req == REQ_RESET) mode = MODE_IDLE;
                end
            endcase
            if (req == REQ_TICK) post(NOTE_READY, 0);
        end

        target = (ptr < STEPS) ? tab_set[ptr] : 12'd0;
        if (int'(target) > start_temp) kind = KIND_HEAT;
        else if (int'(target) < start_temp) kind = KIND_COOL;
        else kind = KIND_HOLD;

        for (int k = 0; k < burst_note.size(); k++) begin
            t_note_rec rec;
            rec.note   = burst_note[k];
            rec.arg    = burst_arg[k];
            rec.mode   = mode;
            rec.step   = ptr[4:0];
            rec.outs   = outs;
            rec.ptime  = ptime;
            rec.stime  = stime;
            rec.kind   = kind;
            rec.target = target;
            rec.last   = (k == burst_note.size() - 1);
            pending_notes.push_back(rec);
        end
    endfunction

    function string show(t_note_rec r);
        return $sformatf({"note=%0d arg=%0d state=%0d step=%0d out=%02h ptime=%0d",
                          " stime=%0d kind=%0d target=%0d last=%0b"},
                         r.note, r.arg, r.mode, r.step, r.outs, r.ptime,
                         r.stime, r.kind, r.target, r.last);
    endfunction

    function void check_note(t_note_rec got);
        t_note_rec want;
        if (pending_notes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected notification: %s", show(got));
        end else begin
            want = pending_notes.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("notification mismatch\n  expected %s\n  actual   %s",
                             show(want), show(got));
                end
            end
        end
    endfunction
endclass

module tb;
    localparam int         STEP_COUNT    = 16;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         SETTLE_CYCLES = 20;
    localparam int         CYCLE_LIMIT   = 2000000;
    localparam int         PHASE_ITEMS   = 72;
    localparam int         SOAK_TICKS    = 24;
    localparam logic [2:0] REQ_SPARE6    = 3'd6;
    localparam logic [2:0] REQ_SPARE7    = 3'd7;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [0:0]  i_cfg_idx       = '0;
    logic [7:0]  i_cfg_wdata     = '0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_req_type      = '0;
    logic [3:0]  i_step_index    = '0;
    logic [11:0] i_step_setpoint = '0;
    logic [15:0] i_step_duration = '0;
    logic [7:0]  i_step_outputs  = '0;
    logic        o_out_valid;
    logic        i_out_ready     = 1'b0;
    logic [2:0]  o_note_type;
    logic [3:0]  o_note_arg;
    logic [2:0]  o_state_code;
    logic [4:0]  o_step_number;
    logic [7:0]  o_output_bits;
    logic [15:0] o_profile_time;
    logic [15:0] o_step_time;
    logic [1:0]  o_step_kind;
    logic [11:0] o_target_now;
    logic        o_last;

    profile_scoreboard #(STEP_COUNT) sb;

    int cycles        = 0;
    int sent          = 0;
    bit idling_on     = 1'b1;
    int hold_requests = 0;
    int holds_seen    = 0;
    int hold_left     = 0;
    int stall_left    = 0;

    ramp_soak_profile_sequencer_core #(.STEP_COUNT(STEP_COUNT)) i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 14);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_note(t_note_rec'({o_note_type, o_note_arg, o_state_code, o_step_number,
                                       o_output_bits, o_profile_time, o_step_time,
                                       o_step_kind, o_target_now, o_last}));
        end
    end

    task automatic send(logic [2:0] req, logic [3:0] idx, logic [11:0] setp,
                        logic [15:0] dur, logic [7:0] outp);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_req_type      <= req;
        i_step_index    <= idx;
        i_step_setpoint <= setp;
        i_step_duration <= dur;
        i_step_outputs  <= outp;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_event(req, idx, setp, dur, outp);
        sent++;
    endtask

    task automatic send_event(logic [2:0] req);
        send(req, 4'($urandom), 12'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // Drop valid, drain every pending notification, then let the core go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending_notes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(logic [7:0] pre, logic [7:0] amb);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_PRESTEP;
        i_cfg_wdata <= pre;
        @(posedge i_clk);
        sb.set_register(CFG_PRESTEP, pre);
        i_cfg_idx   <= CFG_AMBIENT;
        i_cfg_wdata <= amb;
        @(posedge i_clk);
        sb.set_register(CFG_AMBIENT, amb);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 7))
            0: send_event(REQ_START);
            1: send_event(REQ_RESET);
            2: send_event(REQ_STOP);
            3: send_event(REQ_ERROR);
            4: send_event(REQ_SPARE6);
            5: send_event(REQ_SPARE7);
            6: send_event(REQ_WRITE);
            default: send_event(REQ_TICK);
        endcase
    endtask

    // Load a profile of zero to STEP_COUNT steps, start it and mostly tick it toward its end
    task automatic run_profile();
        int          n;
        int          loops;
        logic [11:0] sp;
        logic [15:0] du;
        if (sb.mode == MODE_RUN || sb.mode == MODE_WAIT) send_event(REQ_STOP);
        send_event(REQ_RESET);
        case ($urandom_range(0, 19))
            0, 1, 2: n = 0;
            3, 4:    n = STEP_COUNT;
            default: n = $urandom_range(1, 4);
        endcase
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0:       sp = 12'd0;
                1:       sp = 12'hFFF;
                default: sp = 12'($urandom);
            endcase
            case ($urandom_range(0, 19))
                0:       du = 16'($urandom);
                default: du = 16'($urandom_range(0, 3));
            endcase
            send(REQ_WRITE, i[3:0], sp, du, 8'($urandom));
        end
        if (n < STEP_COUNT) send(REQ_WRITE, n[3:0], 12'd0, 16'd0, 8'($urandom));
        send_event(REQ_START);
        loops = 0;
        while ((sb.mode == MODE_RUN || sb.mode == MODE_WAIT) && loops < 60) begin
            loops++;
            if (sb.mode == MODE_WAIT && $urandom_range(0, 1) == 0) send_event(REQ_RESET);
            else if ($urandom_range(0, 9) != 0) send_event(REQ_TICK);
            else send_noise();
        end
    endtask

    task automatic run_phase(logic [7:0] pre, logic [7:0] amb, bit idle_en, bit squeeze);
        int first;
        settle();
        configure(pre, amb);
        idling_on = idle_en;
        if (squeeze) hold_requests++;
        first = sent;
        while (sent - first < PHASE_ITEMS) run_profile();
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Idle behavior, error with outputs already clear, empty table
        send_event(REQ_TICK);
        send_event(REQ_STOP);
        send_event(REQ_RESET);
        send_event(REQ_ERROR);
        send_event(REQ_RESET);
        send_event(REQ_START);
        send_event(REQ_TICK);
        send_event(REQ_RESET);
        // Zero-duration first step, all outputs on, spare codes as ticks
        send(REQ_WRITE, 4'd0, 12'hFFF, 16'd0, 8'hFF);
        send(REQ_WRITE, 4'd1, 12'h000, 16'd2, 8'h00);
        send(REQ_WRITE, 4'd15, 12'hFFF, 16'hFFFF, 8'h81);
        send_event(REQ_START);
        send_event(REQ_SPARE6);
        send_event(REQ_START);
        send_event(REQ_SPARE7);
        send_event(REQ_TICK);
        send_event(REQ_ERROR);
        send_event(REQ_RESET);
        // Pre-step outputs: stop while waiting, then enter and stop while running
        settle();
        configure(8'h0F, 8'h80);
        send_event(REQ_START);
        send_event(REQ_TICK);
        send_event(REQ_STOP);
        send_event(REQ_RESET);
        send_event(REQ_START);
        send_event(REQ_RESET);
        send_event(REQ_STOP);
        send_event(REQ_RESET);

        // Long first step: tick it a while back to back
        settle();
        configure(8'h00, 8'sd127);
        send(REQ_WRITE, 4'd0, 12'd100, 16'hFFFF, 8'h01);
        send(REQ_WRITE, 4'd1, 12'd100, 16'd3, 8'h80);
        send(REQ_WRITE, 4'd2, 12'd0, 16'd0, 8'h00);
        idling_on = 1'b0;
        send_event(REQ_START);
        repeat (SOAK_TICKS) send_event(REQ_TICK);
        send_event(REQ_RESET);

        run_phase(8'h00, 8'd20, 1'b1, 1'b0);
        run_phase(8'hFF, 8'h7F, 1'b1, 1'b1);
        run_phase(8'h00, 8'h80, 1'b0, 1'b0);
        run_phase(8'($urandom_range(1, 255)), 8'($urandom), 1'b1, 1'b1);
        run_phase(8'h01, 8'h00, 1'b1, 1'b0);
        run_phase(8'h00, 8'($urandom), 1'b0, 1'b0);

        settle();
        if (sb.mismatches == 0 && sb.pending_notes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
